>>> hdl/spwq_pkg.sv
package spwq_pkg;

    // operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // input transaction
    typedef struct packed {
        logic       operation;
        logic [3:0] process_id;
        logic [2:0] priority_req;
    } t_in;

    // result transaction
    typedef struct packed {
        logic [3:0] head_id;
        logic [1:0] status;
        logic [4:0] occupancy;
    } t_out;

    // one queue slot
    typedef struct packed {
        logic       valid;
        logic [3:0] id;
        logic [2:0] prio;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic       enq;
        logic       deq;
        logic [3:0] id;
        logic [2:0] prio;
    } t_cell_ctl;

endpackage

>>> hdl/spwq_cell.sv
module spwq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spwq_pkg::t_cell_ctl i_ctl,
    input  spwq_pkg::t_entry   i_left,
    input  logic               i_left_stays,
    input  spwq_pkg::t_entry   i_right,
    output spwq_pkg::t_entry   o_entry,
    output logic               o_stays
);
    import spwq_pkg::*;

    logic       r_valid;
    logic [3:0] r_id;
    logic [2:0] r_prio;
    t_entry     n_entry;

    // slot holds its place when it is at least as urgent as the new entry
    assign o_stays = r_valid && (r_prio <= i_ctl.prio);
    assign o_entry = '{valid: r_valid, id: r_id, prio: r_prio};

    // next slot contents: hold, take new entry, shift back, or shift forward
    always_comb begin
        n_entry = o_entry;
        if (i_ctl.enq) begin
            if (o_stays) begin
                n_entry = o_entry;
            end else if (i_left_stays) begin
                n_entry = '{valid: 1'b1, id: i_ctl.id, prio: i_ctl.prio};
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right;
        end
    end

    // slot registers, only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
        r_id   <= n_entry.id;
        r_prio <= n_entry.prio;
    end

endmodule

>>> hdl/stable_priority_wait_queue.sv
// stable priority wait queue
// holds up to QUEUE_DEPTH process ids sorted by priority number, 0 most
// urgent; ids of equal priority leave in arrival order.
// input channel: i_in_valid / o_in_ready carry i_in_data with operation
// (enqueue or dequeue), process id and priority.
// output channel: o_out_valid / i_out_ready carry o_out_data with the
// removed head id, a status (ok, empty, full) and the occupancy.
// every input transaction yields exactly one result transaction.
// the result is registered and shows in the cycle after acceptance.
// throughput: one transaction per cycle unless stalled; each slot cell
// decides its next contents from its own compare and its left neighbor's.
// stall: while a result waits and i_out_ready is low, o_in_ready is low
// and the queue holds; with i_out_ready high a new transaction enters in
// the same cycle the previous result leaves.
// reset: synchronous active low; empties the queue and drops any pending
// result. no clearing pass, the block is ready in the first cycle after.
module stable_priority_wait_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  spwq_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output spwq_pkg::t_out o_out_data
);
    import spwq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_entry        cell_q [QUEUE_DEPTH];
    logic          stays  [QUEUE_DEPTH];
    t_cell_ctl     ctl;
    logic          accept;
    logic          full;
    logic          empty;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out          r_out;
    t_out          n_out;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign full        = cell_q[QUEUE_DEPTH-1].valid;
    assign empty       = !cell_q[0].valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // command to the cell row
    always_comb begin
        ctl.enq  = accept && (i_in_data.operation == OP_ENQUEUE) && !full;
        ctl.deq  = accept && (i_in_data.operation == OP_DEQUEUE) && !empty;
        ctl.id   = i_in_data.process_id;
        ctl.prio = i_in_data.priority_req;
    end

    // row of slot cells, slot 0 is the head
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry left_e;
        t_entry right_e;
        logic   left_s;
        if (g == 0) begin : g_head
            assign left_e = '0;
            assign left_s = 1'b1;
        end else begin : g_mid
            assign left_e = cell_q[g-1];
            assign left_s = stays[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_e = '0;
        end else begin : g_body
            assign right_e = cell_q[g+1];
        end
        spwq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_left       (left_e),
            .i_left_stays (left_s),
            .i_right      (right_e),
            .o_entry      (cell_q[g]),
            .o_stays      (stays[g])
        );
    end

    // occupancy and result
    always_comb begin
        n_count = r_count;
        if (ctl.enq) begin
            n_count = r_count + 1'b1;
        end else if (ctl.deq) begin
            n_count = r_count - 1'b1;
        end
        n_out.head_id   = ctl.deq ? cell_q[0].id : 4'd0;
        n_out.occupancy = 5'(n_count);
        if (i_in_data.operation == OP_ENQUEUE) begin
            n_out.status = full ? ST_FULL : ST_OK;
        end else begin
            n_out.status = empty ? ST_EMPTY : ST_OK;
        end
    end

    // count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hdl/spwq_checker.sv
module spwq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input spwq_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input spwq_pkg::t_out o_out_data
);
    import spwq_pkg::*;

    localparam logic [4:0] DEPTH_MOD = 5'(QUEUE_DEPTH);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // every accepted transaction shows a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted transaction gave no result");

    // empty status reports no id and no entries
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_EMPTY) |->
            (o_out_data.head_id == 4'd0) && (o_out_data.occupancy == 5'd0))
        else $error("bad empty result");

    // full status reports a full queue
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_FULL) |->
            (o_out_data.head_id == 4'd0) && (o_out_data.occupancy == DEPTH_MOD))
        else $error("bad full result");

endmodule

bind stable_priority_wait_queue spwq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spwq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
